/* rtl/wiesc_pkg.sv */
// Shared types and constants for the WLAN IE security classifier.
`timescale 1ns / 1ps

package wiesc_pkg;

  // Byte queue between the classifying front end and the parser
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Element ids
  localparam logic [7:0] ID_RSN    = 8'd48;
  localparam logic [7:0] ID_VENDOR = 8'd221;
  localparam logic [7:0] MIN_LEN   = 8'd8;

  // Suite OUIs
  localparam logic [23:0] OUI_IEEE = 24'h000FAC;
  localparam logic [23:0] OUI_MSFT = 24'h0050F2;

  // AKM suite types
  localparam logic [7:0] AKM_8021X     = 8'd1;
  localparam logic [7:0] AKM_8021X_256 = 8'd5;
  localparam logic [7:0] AKM_SUITE_B   = 8'd11;
  localparam logic [7:0] AKM_SUITE_192 = 8'd12;
  localparam logic [7:0] AKM_SAE       = 8'd8;
  localparam logic [7:0] AKM_OWE       = 8'd18;

  // Flag bit positions
  localparam int F_WPA  = 0;
  localparam int F_WPA2 = 1;
  localparam int F_WPA3 = 2;
  localparam int F_OWE  = 3;
  localparam int F_EAP  = 4;
  localparam int FLAG_W = 5;

  // Fallback class codes
  localparam logic [1:0] FB_FLAGS = 2'd0;
  localparam logic [1:0] FB_WEP   = 2'd1;
  localparam logic [1:0] FB_OPEN  = 2'd2;

  // One byte with its precomputed classification
  typedef struct packed {
    logic [7:0] blob_byte;
    logic       last_byte;
    logic       privacy_bit;
    logic       id_rsn;
    logic       id_vendor;
    logic       len_short;
    logic       is_one;
    logic       akm_eap;
    logic       akm_wpa3;
    logic       akm_owe;
  } item_t;

endpackage

/* rtl/wiesc_ifs.sv */
// Handshake interfaces for the IE byte stream and the classification result.
`timescale 1ns / 1ps

interface wiesc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] blob_byte;
  logic       last_byte;
  logic       privacy_bit;

  modport source (output valid, blob_byte, last_byte, privacy_bit, input ready);
  modport sink (input valid, blob_byte, last_byte, privacy_bit, output ready);
endinterface

interface wiesc_result_if;
  logic       valid;
  logic       ready;
  logic       wpa_seen;
  logic       wpa2_seen;
  logic       wpa3_seen;
  logic       owe_seen;
  logic       enterprise_seen;
  logic [1:0] fallback_class;

  modport source (output valid, wpa_seen, wpa2_seen, wpa3_seen, owe_seen,
                  enterprise_seen, fallback_class, input ready);
  modport sink (input valid, wpa_seen, wpa2_seen, wpa3_seen, owe_seen,
                enterprise_seen, fallback_class, output ready);
endinterface

/* rtl/wlan_ie_security_classifier.sv */
// Top level of the WLAN information-element security classifier.
// Throughput: one blob byte per cycle while the queue has room; the parser pops one queued
// byte a cycle, but holds a final byte while the previous result is still not taken.
// A 4-entry byte queue lets input and parser stall independently of each other.
// Reset: synchronous rst clears queue, parser state and result valid; no clearing pass.
`timescale 1ns / 1ps

module wlan_ie_security_classifier import wiesc_pkg::*; (
  input logic            clk,
  input logic            rst,
  wiesc_byte_if.sink     ie_stream,
  wiesc_result_if.source verdict
);

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  wiesc_front u_front (
    .ie_stream  (ie_stream),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  wiesc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  wiesc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .verdict    (verdict)
  );

endmodule

/* rtl/wiesc_front.sv */
// Front end: accepts IE bytes and tags each with its byte-level classification.
`timescale 1ns / 1ps

module wiesc_front import wiesc_pkg::*; (
  wiesc_byte_if.sink ie_stream,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  assign ie_stream.ready = !queue_full;
  assign push            = ie_stream.valid && !queue_full;

  // Classify the byte as a possible id, length or AKM suite type
  always_comb begin
    push_item.blob_byte   = ie_stream.blob_byte;
    push_item.last_byte   = ie_stream.last_byte;
    push_item.privacy_bit = ie_stream.privacy_bit;
    push_item.id_rsn      = ie_stream.blob_byte == ID_RSN;
    push_item.id_vendor   = ie_stream.blob_byte == ID_VENDOR;
    push_item.len_short   = ie_stream.blob_byte < MIN_LEN;
    push_item.is_one      = ie_stream.blob_byte == AKM_8021X;
    push_item.akm_eap     = ie_stream.blob_byte == AKM_8021X
                         || ie_stream.blob_byte == AKM_8021X_256
                         || ie_stream.blob_byte == AKM_SUITE_B
                         || ie_stream.blob_byte == AKM_SUITE_192;
    push_item.akm_wpa3    = ie_stream.blob_byte == AKM_SAE;
    push_item.akm_owe     = ie_stream.blob_byte == AKM_OWE;
  end

endmodule

/* rtl/wiesc_queue.sv */
// Short FIFO of classified bytes between front end and parser.
`timescale 1ns / 1ps

module wiesc_queue import wiesc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/wiesc_back.sv */
// Back end: element walker, RSN/WPA suite classifier and result register.
`timescale 1ns / 1ps

module wiesc_back import wiesc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  wiesc_result_if.source verdict
);

  localparam logic [1:0] PH_ID   = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_RSN    = 2'd1;
  localparam logic [1:0] KIND_VENDOR = 2'd2;

  localparam logic [18:0] NO_COUNT = 19'h7FFFF;

  // Parser state
  logic [1:0]        phase, phase_next;
  logic [1:0]        kind, kind_next;
  logic [7:0]        length, length_next;
  logic [7:0]        offset, offset_next;
  logic [18:0]       sco, sco_next;
  logic [15:0]       remaining, remaining_next;
  logic [23:0]       suite, suite_next;
  logic [FLAG_W-1:0] committed, committed_next;
  logic [FLAG_W-1:0] pending, pending_next;
  logic              reached, reached_next;

  // Result register
  logic              out_valid;
  logic [FLAG_W-1:0] out_flags;
  logic [1:0]        out_class;

  // Combinational helpers
  logic [7:0]        b;
  logic [7:0]        cnt_at;
  logic [15:0]       suite_cnt;
  logic [1:0]        k;
  logic [FLAG_W-1:0] merged;
  logic              do_commit;

  assign b   = head_item.blob_byte;
  assign pop = head_valid && (!head_item.last_byte || !out_valid || verdict.ready);

  // Element walk and suite decode for one byte
  always_comb begin
    phase_next     = phase;
    kind_next      = kind;
    length_next    = length;
    offset_next    = offset;
    sco_next       = sco;
    remaining_next = remaining;
    suite_next     = suite;
    pending_next   = pending;
    reached_next   = reached;
    do_commit      = 1'b0;
    cnt_at         = (kind == KIND_RSN) ? 8'd6 : 8'd10;
    suite_cnt      = {b, remaining[7:0]};
    k              = offset[1:0] - sco[1:0] - 2'd2;

    case (phase)
      PH_ID: begin
        if (head_item.id_rsn) begin
          kind_next = KIND_RSN;
        end else if (head_item.id_vendor) begin
          kind_next = KIND_VENDOR;
        end else begin
          kind_next = KIND_NONE;
        end
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        length_next    = b;
        offset_next    = '0;
        reached_next   = 1'b0;
        remaining_next = '0;
        suite_next     = '0;
        sco_next       = NO_COUNT;
        if (head_item.len_short) begin
          kind_next = KIND_NONE;
        end
        pending_next = '0;
        if (kind == KIND_RSN && !head_item.len_short) begin
          pending_next[F_WPA2] = 1'b1;
        end
        if (b == 8'd0) begin
          do_commit  = 1'b1;
          phase_next = PH_ID;
        end else begin
          phase_next = PH_BODY;
        end
      end
      default: begin
        if (kind != KIND_NONE) begin
          if (kind == KIND_VENDOR && offset < 8'd4) begin
            // Vendor OUI and type
            if (offset < 8'd3) begin
              suite_next = {suite[15:0], b};
            end else if (suite == OUI_MSFT && head_item.is_one) begin
              pending_next[F_WPA] = 1'b1;
            end else begin
              kind_next = KIND_NONE;
            end
          end else if (offset == cnt_at) begin
            remaining_next = {8'd0, b};
          end else if (offset == cnt_at + 8'd1) begin
            // Pairwise count known: locate the AKM count
            sco_next       = 19'(cnt_at) + 19'd2 + {1'b0, suite_cnt, 2'b00};
            remaining_next = '0;
          end else if (sco != NO_COUNT && {11'd0, offset} >= sco) begin
            if ({11'd0, offset} == sco) begin
              remaining_next = {8'd0, b};
            end else if ({12'd0, offset} == {1'b0, sco} + 20'd1) begin
              remaining_next = suite_cnt;
              if (kind == KIND_RSN) begin
                reached_next = 1'b1;
              end
            end else if (k == 2'd0) begin
              suite_next = {16'd0, b};
            end else if (k != 2'd3) begin
              suite_next = {suite[15:0], b};
            end else if (remaining != '0) begin
              // AKM suite type byte
              remaining_next = remaining - 1'b1;
              if (kind == KIND_RSN) begin
                if (suite == OUI_IEEE) begin
                  if (head_item.akm_eap) begin
                    pending_next[F_EAP] = 1'b1;
                  end else if (head_item.akm_wpa3) begin
                    pending_next[F_WPA3] = 1'b1;
                  end else if (head_item.akm_owe) begin
                    pending_next[F_OWE] = 1'b1;
                  end
                end
              end else if (suite == OUI_MSFT && head_item.is_one) begin
                pending_next[F_EAP] = 1'b1;
              end
            end
          end
        end
        offset_next = offset + 8'd1;
        if (offset_next >= length) begin
          do_commit  = 1'b1;
          phase_next = PH_ID;
        end
      end
    endcase

    // Element complete: fold its flags in; OWE overrides WPA2 once an RSN AKM list is reached
    merged = committed | pending_next;
    if (reached_next && merged[F_OWE]) begin
      merged[F_WPA2] = 1'b0;
    end
    committed_next = do_commit ? merged : committed;
  end

  // Parser registers; the last byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (pop && head_item.last_byte)) begin
      phase     <= PH_ID;
      kind      <= KIND_NONE;
      length    <= '0;
      offset    <= '0;
      sco       <= '0;
      remaining <= '0;
      suite     <= '0;
      committed <= '0;
      pending   <= '0;
      reached   <= 1'b0;
    end else if (pop) begin
      phase     <= phase_next;
      kind      <= kind_next;
      length    <= length_next;
      offset    <= offset_next;
      sco       <= sco_next;
      remaining <= remaining_next;
      suite     <= suite_next;
      committed <= committed_next;
      pending   <= pending_next;
      reached   <= reached_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last_byte) begin
      out_flags <= committed_next;
      if (committed_next != '0) begin
        out_class <= FB_FLAGS;
      end else if (head_item.privacy_bit) begin
        out_class <= FB_WEP;
      end else begin
        out_class <= FB_OPEN;
      end
    end
  end

  assign verdict.valid           = out_valid;
  assign verdict.wpa_seen        = out_flags[F_WPA];
  assign verdict.wpa2_seen       = out_flags[F_WPA2];
  assign verdict.wpa3_seen       = out_flags[F_WPA3];
  assign verdict.owe_seen        = out_flags[F_OWE];
  assign verdict.enterprise_seen = out_flags[F_EAP];
  assign verdict.fallback_class  = out_class;

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last_byte |=> phase == PH_ID && committed == '0)
    else $error("parser not restarted after final byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head_item.last_byte))
    else $error("result raised without a final byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict.ready |-> !(pop && head_item.last_byte))
    else $error("pending result overwritten");
`endif

endmodule

/* sim/wlan_ie_security_classifier_test.sv */
// Self-checking testbench for the WLAN IE security classifier: blob stimulus against a predictor.
`timescale 1ns / 1ps

module wlan_ie_security_classifier_test;
  import wiesc_pkg::*;

  localparam int          DIR_ROWS     = 19;
  localparam int          RAND_ITEMS   = 1330;
  localparam int          MIN_BLOBS    = 60;
  localparam int          HOLD_AT      = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PAUSE_BLOB   = 25;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          LIMIT_NS     = 3_000_000;
  localparam logic [7:0]  KIND_SKIP    = 8'd0;
  localparam logic [7:0]  WPA_IE_TYPE  = 8'd1;
  localparam logic [18:0] NO_AKM       = 19'h7FFFF;

  typedef enum logic [1:0] {WALK_ID, WALK_LEN, WALK_BODY} walk_t;

  typedef struct packed {
    logic       wpa;
    logic       wpa2;
    logic       wpa3;
    logic       owe;
    logic       eap;
    logic [1:0] fb;
  } verdict_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       priv;
    logic       typed;
    verdict_t   want;
  } stim_row_t;

  localparam verdict_t V_NONE = '0;
  localparam verdict_t V_OPEN = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FB_OPEN};
  localparam verdict_t V_WEP  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FB_WEP};
  localparam verdict_t V_WPA2 = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FB_FLAGS};

  // Directed blobs; typed verdicts only where the outcome is obvious
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // lone id byte, header cut off
    '{8'h00, 1'b1, 1'b0, 1'b1, V_OPEN},
    '{8'hFF, 1'b1, 1'b1, 1'b1, V_WEP},
    // minimal RSN, pairwise count 0xFFFF runs past the element end
    '{ID_RSN, 1'b0, 1'b0, 1'b0, V_NONE},
    '{MIN_LEN, 1'b0, 1'b1, 1'b0, V_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h0F, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'hAC, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h04, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'hFF, 1'b1, 1'b1, 1'b1, V_WPA2},
    // vendor element with body cut off
    '{ID_VENDOR, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'd200, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b1, 1'b0, 1'b1, V_OPEN},
    // zero-length element, then a zero-length (short) RSN
    '{8'h00, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, V_NONE},
    '{ID_RSN, 1'b0, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b1, 1'b1, 1'b1, V_WEP}
  };

  logic clk;
  logic rst;

  wiesc_byte_if   ie_if();
  wiesc_result_if res_if();

  wlan_ie_security_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .ie_stream(ie_if),
    .verdict  (res_if)
  );

  // Parser shadow state
  walk_t             walk;
  logic [7:0]        kind;
  logic [7:0]        elen;
  logic [7:0]        eoff;
  logic [18:0]       akm_at;
  logic [15:0]       left;
  logic [23:0]       oui;
  logic [FLAG_W-1:0] done_f;
  logic [FLAG_W-1:0] pend_f;
  logic              rsn_akm;

  verdict_t   verdict_q[$];
  logic [7:0] blob_q[$];
  logic [7:0] body_q[$];
  int         errors;
  int         sent_items;
  bit         sender_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void parser_clear();
    walk    = WALK_ID;
    kind    = '0;
    elen    = '0;
    eoff    = '0;
    akm_at  = '0;
    left    = '0;
    oui     = '0;
    done_f  = '0;
    pend_f  = '0;
    rsn_akm = 1'b0;
  endfunction

  // Fold element flags in; OWE seen with an RSN AKM list drops WPA2
  function automatic void commit_flags();
    done_f = done_f | pend_f;
    if (rsn_akm && done_f[F_OWE]) done_f[F_WPA2] = 1'b0;
  endfunction

  function automatic void rate_suite(logic [7:0] t);
    if (kind == ID_RSN) begin
      if (oui == OUI_IEEE) begin
        case (t)
          AKM_8021X, AKM_8021X_256, AKM_SUITE_B, AKM_SUITE_192: pend_f[F_EAP] = 1'b1;
          AKM_SAE: pend_f[F_WPA3] = 1'b1;
          AKM_OWE: pend_f[F_OWE] = 1'b1;
          default: ;
        endcase
      end
    end else if (oui == OUI_MSFT && t == AKM_8021X) begin
      pend_f[F_EAP] = 1'b1;
    end
  endfunction

  function automatic void body_step(logic [7:0] b, logic [7:0] off);
    logic [18:0] cnt_at;
    logic [18:0] rel;
    cnt_at = (kind == ID_RSN) ? 19'd6 : 19'd10;
    if (kind == ID_VENDOR && off < 8'd4) begin
      if (off < 8'd3) oui = {oui[15:0], b};
      else if (oui == OUI_MSFT && b == WPA_IE_TYPE) pend_f[F_WPA] = 1'b1;
      else kind = KIND_SKIP;
    end else if (off == cnt_at) begin
      left = {8'h00, b};
    end else if (off == cnt_at + 19'd1) begin
      // pairwise list skipped: AKM count sits right behind it
      left   = left | {b, 8'h00};
      akm_at = cnt_at + 19'd2 + {1'b0, left, 2'b00};
      left   = '0;
    end else if (akm_at != NO_AKM && off >= akm_at) begin
      if (off == akm_at) begin
        left = {8'h00, b};
      end else if (off == akm_at + 19'd1) begin
        left = left | {b, 8'h00};
        if (kind == ID_RSN) rsn_akm = 1'b1;
      end else begin
        rel = off - akm_at - 19'd2;
        if (rel[1:0] == 2'd0) oui = {16'h0000, b};
        else if (rel[1:0] != 2'd3) oui = {oui[15:0], b};
        else if (left != 0) begin
          rate_suite(b);
          left = left - 16'd1;
        end
      end
    end
  endfunction

  // One accepted byte; returns 1 with the verdict when it closes the blob
  function automatic logic walk_byte(logic [7:0] b, logic last, logic priv,
                                     output verdict_t v);
    v = '0;
    case (walk)
      WALK_ID: begin
        kind = b;
        walk = WALK_LEN;
      end
      WALK_LEN: begin
        elen    = b;
        eoff    = '0;
        pend_f  = '0;
        rsn_akm = 1'b0;
        left    = '0;
        oui     = '0;
        akm_at  = NO_AKM;
        if ((kind != ID_RSN && kind != ID_VENDOR) || b < MIN_LEN) kind = KIND_SKIP;
        if (kind == ID_RSN) pend_f[F_WPA2] = 1'b1;
        if (b == 8'd0) begin
          commit_flags();
          walk = WALK_ID;
        end else begin
          walk = WALK_BODY;
        end
      end
      default: begin
        if (kind != KIND_SKIP) body_step(b, eoff);
        eoff = eoff + 8'd1;
        if (eoff >= elen) begin
          commit_flags();
          walk = WALK_ID;
        end
      end
    endcase
    if (!last) return 1'b0;
    v.wpa  = done_f[F_WPA];
    v.wpa2 = done_f[F_WPA2];
    v.wpa3 = done_f[F_WPA3];
    v.owe  = done_f[F_OWE];
    v.eap  = done_f[F_EAP];
    v.fb   = (done_f != '0) ? FB_FLAGS : (priv ? FB_WEP : FB_OPEN);
    parser_clear();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  // Drive one byte transaction and predict on acceptance
  task automatic send_byte(logic [7:0] b, logic last, logic priv, logic typed, verdict_t want);
    int       gap;
    verdict_t v;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      ie_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ie_if.valid       <= 1'b1;
    ie_if.blob_byte   <= b;
    ie_if.last_byte   <= last;
    ie_if.privacy_bit <= priv;
    do @(posedge clk); while (!ie_if.ready);
    if (walk_byte(b, last, priv, v)) verdict_q.push_back(typed ? want : v);
    sent_items++;
  endtask

  // Blob construction helpers
  function automatic void put_suite(logic [23:0] o, logic [7:0] t);
    body_q.push_back(o[23:16]);
    body_q.push_back(o[15:8]);
    body_q.push_back(o[7:0]);
    body_q.push_back(t);
  endfunction

  function automatic void put_count(int n);
    logic [15:0] c;
    c = 16'(n);
    if ($urandom_range(0, 9) == 0) c = 16'($urandom_range(0, 65535));
    body_q.push_back(c[7:0]);
    body_q.push_back(c[15:8]);
  endfunction

  function automatic void emit_element(logic [7:0] id);
    int len;
    len = body_q.size();
    // occasionally a length that disagrees with the body
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len + 3);
    if (len > 255) len = 255;
    blob_q.push_back(id);
    blob_q.push_back(len[7:0]);
    foreach (body_q[i]) blob_q.push_back(body_q[i]);
  endfunction

  function automatic logic [7:0] pick_rsn_akm();
    case ($urandom_range(0, 7))
      0: return AKM_8021X;
      1: return AKM_8021X_256;
      2: return AKM_SAE;
      3: return AKM_SUITE_B;
      4: return AKM_SUITE_192;
      5: return AKM_OWE;
      6: return 8'd2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_rsn();
    int          np;
    int          na;
    logic [23:0] o;
    body_q.delete();
    body_q.push_back(8'h01);
    body_q.push_back(8'h00);
    put_suite(OUI_IEEE, 8'($urandom_range(1, 10)));
    np = $urandom_range(0, 2);
    put_count(np);
    repeat (np) put_suite(OUI_IEEE, 8'd4);
    na = $urandom_range(0, 3);
    put_count(na);
    repeat (na) begin
      o = ($urandom_range(0, 7) == 0) ? 24'($urandom) : OUI_IEEE;
      put_suite(o, pick_rsn_akm());
    end
    if ($urandom_range(0, 1) == 0) begin
      body_q.push_back(8'($urandom_range(0, 255)));
      body_q.push_back(8'($urandom_range(0, 255)));
    end
    emit_element(ID_RSN);
  endfunction

  function automatic void build_wpa();
    int          np;
    int          na;
    logic [23:0] o;
    logic [7:0]  t;
    body_q.delete();
    o = ($urandom_range(0, 7) == 0) ? 24'($urandom) : OUI_MSFT;
    t = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : WPA_IE_TYPE;
    body_q.push_back(o[23:16]);
    body_q.push_back(o[15:8]);
    body_q.push_back(o[7:0]);
    body_q.push_back(t);
    body_q.push_back(8'h01);
    body_q.push_back(8'h00);
    put_suite(OUI_MSFT, 8'($urandom_range(0, 5)));
    np = $urandom_range(0, 2);
    put_count(np);
    repeat (np) put_suite(OUI_MSFT, 8'd2);
    na = $urandom_range(0, 3);
    put_count(na);
    repeat (na) begin
      o = ($urandom_range(0, 7) == 0) ? OUI_IEEE : OUI_MSFT;
      case ($urandom_range(0, 3))
        0, 1: t = AKM_8021X;
        2: t = 8'd2;
        default: t = 8'($urandom_range(0, 255));
      endcase
      put_suite(o, t);
    end
    emit_element(ID_VENDOR);
  endfunction

  function automatic void build_other();
    int len;
    body_q.delete();
    len = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 12);
    repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
    emit_element(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed elements, some noise, sometimes cut short
  function automatic void build_blob();
    int n;
    blob_q.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) blob_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 8))
        0, 1, 2, 3: build_rsn();
        4, 5: build_wpa();
        6, 7: build_other();
        default: repeat ($urandom_range(1, 3)) blob_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 4) == 0 && blob_q.size() > 1) begin
      n = $urandom_range(1, blob_q.size() - 1);
      repeat (n) void'(blob_q.pop_back());
    end
  endfunction

  // Result side: random stalls, one long hold-off, check each transaction
  initial begin
    int       gap;
    int       got_n;
    bit       calm;
    verdict_t got;
    verdict_t want;
    got_n = 0;
    calm  = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 11);
      if (got_n == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got = '{res_if.wpa_seen, res_if.wpa2_seen, res_if.wpa3_seen, res_if.owe_seen,
              res_if.enterprise_seen, res_if.fallback_class};
      if (verdict_q.size() == 0) begin
        flag_mismatch("verdict with none pending", 0, int'(got));
      end else begin
        want = verdict_q.pop_front();
        if (got.wpa !== want.wpa) flag_mismatch("wpa_seen", want.wpa, got.wpa);
        if (got.wpa2 !== want.wpa2) flag_mismatch("wpa2_seen", want.wpa2, got.wpa2);
        if (got.wpa3 !== want.wpa3) flag_mismatch("wpa3_seen", want.wpa3, got.wpa3);
        if (got.owe !== want.owe) flag_mismatch("owe_seen", want.owe, got.owe);
        if (got.eap !== want.eap) flag_mismatch("enterprise_seen", want.eap, got.eap);
        if (got.fb !== want.fb) flag_mismatch("fallback_class", want.fb, got.fb);
      end
      got_n++;
      if (got_n % 16 == 0) calm = ($urandom_range(0, 2) == 0);
    end
  end

  // Byte side: directed table, then random blobs
  initial begin
    int blobs;
    int rand_start;
    errors      = 0;
    sent_items  = 0;
    blobs       = 0;
    sender_calm = 1'b0;
    parser_clear();
    rst               <= 1'b1;
    ie_if.valid       <= 1'b0;
    ie_if.blob_byte   <= '0;
    ie_if.last_byte   <= 1'b0;
    ie_if.privacy_bit <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_byte(DIRECTED[r].b, DIRECTED[r].last, DIRECTED[r].priv, DIRECTED[r].typed,
                DIRECTED[r].want);

    rand_start = sent_items;
    while (sent_items - rand_start < RAND_ITEMS || blobs < MIN_BLOBS) begin
      build_blob();
      sender_calm = ($urandom_range(0, 4) == 0);
      foreach (blob_q[i])
        send_byte(blob_q[i], i == blob_q.size() - 1, 1'($urandom_range(0, 1)), 1'b0, V_NONE);
      blobs++;
      // let the block drain completely once
      if (blobs == PAUSE_BLOB) begin
        ie_if.valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
      end
    end
    ie_if.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
